// File: src/cisac_pkg.sv
`default_nettype none

package cisac_pkg;

    localparam int DEFAULT_MAX_PATTERN = 8;

    localparam int TEXT_W      = 8;
    localparam int CFG_DATA_W  = 64;
    localparam int LEN_W       = 4;
    localparam int COUNT_W     = 16;
    localparam int OUT_TDATA_W = 24;

    localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_BYTES  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_LENGTH = 1'b1;

    localparam logic [CFG_DATA_W-1:0] PATTERN_BYTES_RESET  = '0;
    localparam logic [LEN_W-1:0]      PATTERN_LENGTH_RESET = 4'd1;

    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

    localparam logic [TEXT_W-1:0] LOWER_A     = 8'h61;
    localparam logic [TEXT_W-1:0] LOWER_Z     = 8'h7A;
    localparam logic [TEXT_W-1:0] CASE_OFFSET = 8'h20;

    function automatic logic [TEXT_W-1:0] fold_upper(input logic [TEXT_W-1:0] c);
        logic [TEXT_W-1:0] r;
        r = c;
        if (c >= LOWER_A && c <= LOWER_Z) begin
            r = c - CASE_OFFSET;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// File: src/cisac_front.sv
`default_nettype none

module cisac_front #(
    parameter int MAX_PATTERN = cisac_pkg::DEFAULT_MAX_PATTERN,
    parameter int SEEN_W      = $clog2(MAX_PATTERN + 1),
    parameter int ENTRY_W     = 2 * MAX_PATTERN + SEEN_W + 1
) (
    input  wire logic [cisac_pkg::TEXT_W-1:0]     text_byte,
    input  wire logic                             text_end,
    input  wire logic [cisac_pkg::CFG_DATA_W-1:0] pattern_bytes,
    input  wire logic [cisac_pkg::LEN_W-1:0]      pattern_length,
    output logic      [ENTRY_W-1:0]               entry
);

    logic [cisac_pkg::TEXT_W-1:0] text_fold;
    logic [SEEN_W-1:0]            act_len;
    logic [MAX_PATTERN-1:0]       eq_mask;
    logic [MAX_PATTERN-1:0]       top_sel;

    always_comb begin
        if (pattern_length == '0) begin
            act_len = SEEN_W'(1);
        end else if (pattern_length > cisac_pkg::LEN_W'(MAX_PATTERN)) begin
            act_len = SEEN_W'(MAX_PATTERN);
        end else begin
            act_len = SEEN_W'(pattern_length);
        end
    end

    assign text_fold = cisac_pkg::fold_upper(text_byte);

    // one compare lane per pattern position
    always_comb begin
        for (int i = 0; i < MAX_PATTERN; i++) begin
            eq_mask[i] = (cisac_pkg::fold_upper(pattern_bytes[8*i +: 8]) == text_fold)
                         && (SEEN_W'(i) < act_len);
            top_sel[i] = (act_len == SEEN_W'(i + 1));
        end
    end

    assign entry = {text_end, act_len, top_sel, eq_mask};

endmodule

`default_nettype wire

// File: src/cisac_queue.sv
`default_nettype none

module cisac_queue #(
    parameter int DATA_W = 8
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              push_valid,
    output logic                   push_ready,
    input  wire logic [DATA_W-1:0] push_data,
    output logic                   pop_valid,
    input  wire logic              pop_ready,
    output logic      [DATA_W-1:0] pop_data
);

    logic [DATA_W-1:0] mem [cisac_pkg::QUEUE_DEPTH];

    logic [cisac_pkg::QUEUE_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [cisac_pkg::QUEUE_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [cisac_pkg::QUEUE_CNT_W-1:0] cnt_reg, cnt_next;

    logic push, pop;

    assign push_ready = (cnt_reg != cisac_pkg::QUEUE_CNT_W'(cisac_pkg::QUEUE_DEPTH));
    assign pop_valid  = (cnt_reg != '0);
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;
    assign pop_data   = mem[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == cisac_pkg::QUEUE_PTR_W'(cisac_pkg::QUEUE_DEPTH - 1))
                          ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == cisac_pkg::QUEUE_PTR_W'(cisac_pkg::QUEUE_DEPTH - 1))
                          ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            cnt_next = cnt_reg + 1'b1;
        end else if (pop && !push) begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

    a_cnt_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= cisac_pkg::QUEUE_CNT_W'(cisac_pkg::QUEUE_DEPTH))
        else $error("queue count beyond depth");

    a_cnt_track: assert property (@(posedge aclk) disable iff (!aresetn)
        push && !pop |=> cnt_reg == $past(cnt_reg) + 1'b1)
        else $error("queue count missed a push");

    a_ptr_gap: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg == '0 |-> wr_ptr_reg == rd_ptr_reg)
        else $error("empty queue with pointers apart");

endmodule

`default_nettype wire

// File: src/cisac_back.sv
`default_nettype none

module cisac_back #(
    parameter int MAX_PATTERN = cisac_pkg::DEFAULT_MAX_PATTERN,
    parameter int SEEN_W      = $clog2(MAX_PATTERN + 1),
    parameter int ENTRY_W     = 2 * MAX_PATTERN + SEEN_W + 1
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          entry_valid,
    output logic                               entry_ready,
    input  wire logic [ENTRY_W-1:0]            entry,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output logic                               out_match_here,
    output logic      [cisac_pkg::COUNT_W-1:0] out_match_total,
    output logic                               out_too_short,
    output logic                               out_last
);

    logic [MAX_PATTERN-1:0] eq_mask, top_sel;
    logic [SEEN_W-1:0]      act_len;
    logic                   last;

    logic [MAX_PATTERN-1:0]        prefix_reg, prefix_next;
    logic [cisac_pkg::COUNT_W-1:0] count_reg, count_next;
    logic [SEEN_W-1:0]             seen_reg, seen_next;

    logic                          valid_reg, valid_next;
    logic                          hit_reg;
    logic [cisac_pkg::COUNT_W-1:0] total_reg;
    logic                          short_reg;
    logic                          last_reg;

    logic pop, hit, short_flag;

    assign {last, act_len, top_sel, eq_mask} = entry;

    assign entry_ready = !valid_reg || out_ready;
    assign pop         = entry_valid && entry_ready;

    // shift-and step
    always_comb begin
        prefix_next = MAX_PATTERN'({prefix_reg, 1'b1});
        prefix_next = prefix_next & eq_mask;
        hit         = |(prefix_next & top_sel);
        count_next  = (hit && count_reg != cisac_pkg::COUNT_MAX) ? count_reg + 1'b1 : count_reg;
        seen_next   = (seen_reg == SEEN_W'(MAX_PATTERN)) ? seen_reg : seen_reg + 1'b1;
        short_flag  = last && (seen_next < act_len);
    end

    assign valid_next = pop ? 1'b1 : (out_ready ? 1'b0 : valid_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prefix_reg <= '0;
            count_reg  <= '0;
            seen_reg   <= '0;
            valid_reg  <= 1'b0;
        end else begin
            valid_reg <= valid_next;
            if (pop) begin
                if (last) begin
                    prefix_reg <= '0;
                    count_reg  <= '0;
                    seen_reg   <= '0;
                end else begin
                    prefix_reg <= prefix_next;
                    count_reg  <= count_next;
                    seen_reg   <= seen_next;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (pop) begin
            hit_reg   <= hit;
            total_reg <= count_next;
            short_reg <= short_flag;
            last_reg  <= last;
        end
    end

    assign out_valid       = valid_reg;
    assign out_match_here  = hit_reg;
    assign out_match_total = total_reg;
    assign out_too_short   = short_reg;
    assign out_last        = last_reg;

    a_short_no_hit: assert property (@(posedge aclk) disable iff (!aresetn)
        valid_reg && short_reg |-> !hit_reg)
        else $error("too-short result with a match");

    a_short_on_last: assert property (@(posedge aclk) disable iff (!aresetn)
        valid_reg && short_reg |-> last_reg)
        else $error("too-short flag on a beat that is not last");

    a_hit_counted: assert property (@(posedge aclk) disable iff (!aresetn)
        valid_reg && hit_reg |-> total_reg != '0)
        else $error("match with zero total");

    a_clear_after_last: assert property (@(posedge aclk) disable iff (!aresetn)
        pop && last |=> prefix_reg == '0 && count_reg == '0 && seen_reg == '0)
        else $error("state not cleared after last beat");

endmodule

`default_nettype wire

// File: src/case_insensitive_shift_and_count_unit.sv
`default_nettype none

// Case-insensitive shift-and occurrence counter.
// Configuration: write cfg_index 0 for the pattern bytes (position 0 in the
// lowest byte) and cfg_index 1 for the pattern length; cfg_ready is always
// high. Write only while no text is in flight.
// Input stream: one text byte per beat in s_axis_tdata[7:0], s_axis_tlast
// marks the final byte of a text. Each input beat yields exactly one output
// beat: match flag, running saturating count, too-short flag and tlast.
// An accepted beat passes the queue and the back's output register before it
// shows on m_axis. Throughput is one beat per cycle while m_axis_tready is
// high; the front folds case and builds the per-position match mask, the
// back applies the shift-and update, and a two-entry queue sits between them.
// When the receiver stalls, the output register holds its beat and the
// queue absorbs two more before s_axis_tready drops.
// Reset clears the match state, the count, the queue and the output valid,
// and returns the pattern to zero with length one.

module case_insensitive_shift_and_count_unit #(
    parameter int MAX_PATTERN = cisac_pkg::DEFAULT_MAX_PATTERN
) (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    input  wire logic                               s_axis_tvalid,
    output logic                                    s_axis_tready,
    input  wire logic [cisac_pkg::TEXT_W-1:0]       s_axis_tdata,  // text_byte
    input  wire logic                               s_axis_tlast,
    output logic                                    m_axis_tvalid,
    input  wire logic                               m_axis_tready,
    // match_here [0], match_total [16:1], too_short [17], zero [23:18]
    output logic      [cisac_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
    output logic                                    m_axis_tlast,
    input  wire logic                               cfg_valid,
    output logic                                    cfg_ready,
    input  wire logic [cisac_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [cisac_pkg::CFG_DATA_W-1:0]   cfg_data
);

    localparam int SEEN_W  = $clog2(MAX_PATTERN + 1);
    localparam int ENTRY_W = 2 * MAX_PATTERN + SEEN_W + 1;

    logic [cisac_pkg::CFG_DATA_W-1:0] pattern_bytes_reg;
    logic [cisac_pkg::LEN_W-1:0]      pattern_length_reg;

    logic [ENTRY_W-1:0] front_entry, queue_entry;
    logic               queue_valid, back_ready;

    logic                          out_match_here, out_too_short;
    logic [cisac_pkg::COUNT_W-1:0] out_match_total;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pattern_bytes_reg  <= cisac_pkg::PATTERN_BYTES_RESET;
            pattern_length_reg <= cisac_pkg::PATTERN_LENGTH_RESET;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                cisac_pkg::CFG_PATTERN_BYTES: begin
                    pattern_bytes_reg <= cfg_data;
                end
                cisac_pkg::CFG_PATTERN_LENGTH: begin
                    pattern_length_reg <= cfg_data[cisac_pkg::LEN_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    cisac_front #(
        .MAX_PATTERN (MAX_PATTERN),
        .SEEN_W      (SEEN_W),
        .ENTRY_W     (ENTRY_W)
    ) u_front (
        .text_byte      (s_axis_tdata),
        .text_end       (s_axis_tlast),
        .pattern_bytes  (pattern_bytes_reg),
        .pattern_length (pattern_length_reg),
        .entry          (front_entry)
    );

    cisac_queue #(
        .DATA_W (ENTRY_W)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (s_axis_tvalid),
        .push_ready (s_axis_tready),
        .push_data  (front_entry),
        .pop_valid  (queue_valid),
        .pop_ready  (back_ready),
        .pop_data   (queue_entry)
    );

    cisac_back #(
        .MAX_PATTERN (MAX_PATTERN),
        .SEEN_W      (SEEN_W),
        .ENTRY_W     (ENTRY_W)
    ) u_back (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .entry_valid     (queue_valid),
        .entry_ready     (back_ready),
        .entry           (queue_entry),
        .out_valid       (m_axis_tvalid),
        .out_ready       (m_axis_tready),
        .out_match_here  (out_match_here),
        .out_match_total (out_match_total),
        .out_too_short   (out_too_short),
        .out_last        (m_axis_tlast)
    );

    assign m_axis_tdata = {
        (cisac_pkg::OUT_TDATA_W - cisac_pkg::COUNT_W - 2)'(0),
        out_too_short,
        out_match_total,
        out_match_here
    };

endmodule

`default_nettype wire

// File: sim/tb_case_insensitive_shift_and_count_unit.sv
`default_nettype none

module tb_case_insensitive_shift_and_count_unit;

    localparam int unsigned CYCLE_LIMIT = 400000;

    typedef struct packed {
        logic                          match_here;
        logic [cisac_pkg::COUNT_W-1:0] match_total;
        logic                          too_short;
        logic                          result_last;
    } scan_result_t;

    logic                                aclk = 1'b0;
    logic                                aresetn = 1'b0;
    logic                                s_axis_tvalid = 1'b0;
    logic                                s_axis_tready;
    logic [cisac_pkg::TEXT_W-1:0]        s_axis_tdata = '0;    // text_byte
    logic                                s_axis_tlast = 1'b0;
    logic                                m_axis_tvalid;
    logic                                m_axis_tready = 1'b0;
    // match_here [0], match_total [16:1], too_short [17], zero [23:18]
    logic [cisac_pkg::OUT_TDATA_W-1:0]   m_axis_tdata;
    logic                                m_axis_tlast;
    logic                                cfg_valid = 1'b0;
    logic                                cfg_ready;
    logic [cisac_pkg::CFG_IDX_W-1:0]     cfg_index = '0;
    logic [cisac_pkg::CFG_DATA_W-1:0]    cfg_data = '0;

    // pattern registers as the block should hold them
    logic [cisac_pkg::CFG_DATA_W-1:0]    pattern_reg = cisac_pkg::PATTERN_BYTES_RESET;
    logic [cisac_pkg::LEN_W-1:0]         pattern_len_reg = cisac_pkg::PATTERN_LENGTH_RESET;
    // scan state as the block should hold it
    logic [7:0]                          prefix_bits = '0;
    logic [cisac_pkg::COUNT_W-1:0]       hit_count = '0;
    int unsigned                         bytes_counted = 0;

    scan_result_t                        pending_results[$];
    int unsigned                         tx_idle_pct = 0;
    int unsigned                         rx_idle_pct = 0;
    int unsigned                         rx_stall_cycles = 0;
    int unsigned                         error_count = 0;
    int unsigned                         cycle_count = 0;

    case_insensitive_shift_and_count_unit dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always #5 aclk = ~aclk;

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    function automatic logic [7:0] to_upper_case(input logic [7:0] c);
        if (c >= cisac_pkg::LOWER_A && c <= cisac_pkg::LOWER_Z) begin
            return c - cisac_pkg::CASE_OFFSET;
        end
        return c;
    endfunction

    function automatic int unsigned active_len();
        if (pattern_len_reg < 1) begin
            return 1;
        end
        if (pattern_len_reg > cisac_pkg::DEFAULT_MAX_PATTERN) begin
            return cisac_pkg::DEFAULT_MAX_PATTERN;
        end
        return 32'(pattern_len_reg);
    endfunction

    function automatic scan_result_t scan_byte(input logic [7:0] b, input logic e);
        int unsigned  len;
        int unsigned  i;
        logic [7:0]   c;
        logic [7:0]   eq;
        scan_result_t r;
        len = active_len();
        c = to_upper_case(b);
        eq = '0;
        for (i = 0; i < len; i++) begin
            if (to_upper_case(pattern_reg[8*i +: 8]) == c) begin
                eq[i] = 1'b1;
            end
        end
        prefix_bits = ((prefix_bits << 1) | 8'd1) & eq;
        r.match_here = prefix_bits[len-1];
        if (r.match_here && hit_count != cisac_pkg::COUNT_MAX) begin
            hit_count++;
        end
        if (bytes_counted < 8) begin
            bytes_counted++;
        end
        r.match_total = hit_count;
        r.too_short = e && (bytes_counted < len);
        r.result_last = e;
        if (e) begin
            prefix_bits = '0;
            hit_count = '0;
            bytes_counted = 0;
        end
        return r;
    endfunction

    // result side
    always @(negedge aclk) begin
        if (rx_stall_cycles > 0) begin
            m_axis_tready <= 1'b0;
            rx_stall_cycles = rx_stall_cycles - 1;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    always @(posedge aclk) begin
        scan_result_t want;
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            if (pending_results.size() == 0) begin
                $error("result beat with nothing pending: tdata %h", m_axis_tdata);
                error_count++;
            end else begin
                want = pending_results.pop_front();
                if (m_axis_tdata[0] !== want.match_here) begin
                    $error("match_here: expected %0d, got %0d",
                           want.match_here, m_axis_tdata[0]);
                    error_count++;
                end
                if (m_axis_tdata[16:1] !== want.match_total) begin
                    $error("match_total: expected %0d, got %0d",
                           want.match_total, m_axis_tdata[16:1]);
                    error_count++;
                end
                if (m_axis_tdata[17] !== want.too_short) begin
                    $error("too_short: expected %0d, got %0d",
                           want.too_short, m_axis_tdata[17]);
                    error_count++;
                end
                if (m_axis_tlast !== want.result_last) begin
                    $error("result_last: expected %0d, got %0d",
                           want.result_last, m_axis_tlast);
                    error_count++;
                end
            end
        end
    end

    task automatic send_byte(input logic [7:0] b, input logic e);
        @(negedge aclk);
        while (tx_idle_pct != 0 && $urandom_range(99) < tx_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= b;
        s_axis_tlast <= e;
        do @(posedge aclk); while (!s_axis_tready);
        pending_results.push_back(scan_byte(b, e));
    endtask

    task automatic send_text(input string txt, input logic close);
        int i;
        for (i = 0; i < txt.len(); i++) begin
            send_byte(txt[i], close && (i == txt.len() - 1));
        end
    endtask

    task automatic wait_idle();
        @(negedge aclk);
        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (3) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [cisac_pkg::CFG_IDX_W-1:0] idx,
                             input logic [cisac_pkg::CFG_DATA_W-1:0] val);
        wait_idle();
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge aclk); while (!cfg_ready);
        if (idx == cisac_pkg::CFG_PATTERN_BYTES) begin
            pattern_reg = val;
        end else begin
            pattern_len_reg = val[cisac_pkg::LEN_W-1:0];
        end
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    task automatic test_defaults();
        // zero pattern byte of length one matches the zero character
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h00, 1'b1);
    endtask

    task automatic test_case_folding();
        // only a-z fold, neighbors like backtick and brace stay apart
        write_reg(cisac_pkg::CFG_PATTERN_BYTES, {32'h0, 8'h7B, 8'h61, 8'h60, 8'h7A});
        write_reg(cisac_pkg::CFG_PATTERN_LENGTH, 64'd4);
        send_text("Z`A{z@a[", 1'b1);
    endtask

    task automatic test_overlap();
        write_reg(cisac_pkg::CFG_PATTERN_BYTES, {40'h0, "ana"});
        write_reg(cisac_pkg::CFG_PATTERN_LENGTH, 64'd3);
        send_text("BaNaNa", 1'b1);
    endtask

    task automatic test_too_short();
        int i;
        write_reg(cisac_pkg::CFG_PATTERN_BYTES, {cisac_pkg::CFG_DATA_W{1'b1}});
        write_reg(cisac_pkg::CFG_PATTERN_LENGTH, 64'd15);
        send_byte(8'hFF, 1'b0);
        send_byte(8'hFF, 1'b1);
        for (i = 0; i < 9; i++) begin
            send_byte(8'hFF, i == 8);
        end
    endtask

    task automatic test_length_clamp();
        write_reg(cisac_pkg::CFG_PATTERN_BYTES, {56'h0, 8'h78});
        write_reg(cisac_pkg::CFG_PATTERN_LENGTH, 64'd0);
        send_text("xX", 1'b1);
    endtask

    task automatic test_midtext_config();
        // prefix state survives a pattern change inside a text
        write_reg(cisac_pkg::CFG_PATTERN_BYTES, {48'h0, "ba"});
        write_reg(cisac_pkg::CFG_PATTERN_LENGTH, 64'd2);
        send_byte("a", 1'b0);
        write_reg(cisac_pkg::CFG_PATTERN_BYTES, {48'h0, "bc"});
        send_byte("B", 1'b0);
        send_byte("x", 1'b1);
    endtask

    task automatic test_output_stall();
        int i;
        write_reg(cisac_pkg::CFG_PATTERN_BYTES, {48'h0, "BA"});
        write_reg(cisac_pkg::CFG_PATTERN_LENGTH, 64'd2);
        tx_idle_pct = 0;
        wait_idle();
        rx_stall_cycles = 60;
        for (i = 0; i < 24; i++) begin
            send_byte((i % 2) ? "b" : "A", i == 23);
        end
    endtask

    function automatic logic [cisac_pkg::CFG_DATA_W-1:0] random_pattern();
        logic [cisac_pkg::CFG_DATA_W-1:0] p;
        int                               i;
        case ($urandom_range(7))
            0: p = '1;
            1: p = '0;
            2: p = {$urandom, $urandom};
            default: begin
                for (i = 0; i < 8; i++) begin
                    case ($urandom_range(5))
                        0: p[8*i +: 8] = "A";
                        1: p[8*i +: 8] = "b";
                        2: p[8*i +: 8] = "a";
                        3: p[8*i +: 8] = "B";
                        4: p[8*i +: 8] = 8'h00;
                        default: p[8*i +: 8] = 8'($urandom_range(255));
                    endcase
                end
            end
        endcase
        return p;
    endfunction

    function automatic logic [cisac_pkg::CFG_DATA_W-1:0] random_length();
        logic [cisac_pkg::CFG_DATA_W-1:0] v;
        v = {$urandom, $urandom};
        if ($urandom_range(5) == 0) begin
            v[cisac_pkg::LEN_W-1:0] = cisac_pkg::LEN_W'($urandom_range(15));
        end else begin
            v[cisac_pkg::LEN_W-1:0] = cisac_pkg::LEN_W'($urandom_range(4, 1));
        end
        return v;
    endfunction

    function automatic logic [7:0] pick_text_char();
        logic [7:0] c;
        if ($urandom_range(99) < 70) begin
            c = pattern_reg[8*$urandom_range(active_len() - 1) +: 8];
            if (to_upper_case(c) >= "A" && to_upper_case(c) <= "Z" && $urandom_range(1)) begin
                c = c ^ cisac_pkg::CASE_OFFSET;
            end
        end else begin
            c = 8'($urandom_range(255));
        end
        return c;
    endfunction

    task automatic test_random_texts(input int unsigned tx, input int unsigned rx,
                                     input int unsigned n_items);
        int unsigned sent;
        int unsigned tlen;
        int unsigned j;
        tx_idle_pct = tx;
        rx_idle_pct = rx;
        sent = 0;
        while (sent < n_items) begin
            if ($urandom_range(3) == 0) begin
                write_reg(cisac_pkg::CFG_PATTERN_BYTES, random_pattern());
                write_reg(cisac_pkg::CFG_PATTERN_LENGTH, random_length());
            end
            tlen = $urandom_range(20, 1);
            for (j = 0; j < tlen; j++) begin
                send_byte(pick_text_char(), (j == tlen - 1) && ($urandom_range(7) != 0));
                sent++;
            end
        end
    endtask

    initial begin
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        tx_idle_pct = 27;
        rx_idle_pct = 79;
        test_defaults();
        test_case_folding();
        test_overlap();
        test_too_short();
        test_length_clamp();
        test_midtext_config();
        test_output_stall();
        test_random_texts(27, 79, 120);
        test_random_texts(79, 27, 120);
        test_random_texts(0, 0, 120);
        wait_idle();
        repeat (5) @(posedge aclk);
        if (error_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

`default_nettype wire

// File: sim.f
src/cisac_pkg.sv
src/cisac_front.sv
src/cisac_queue.sv
src/cisac_back.sv
src/case_insensitive_shift_and_count_unit.sv
sim/tb_case_insensitive_shift_and_count_unit.sv
